@@ rtl/rcc_pkg.sv @@
// rcc_pkg: shared types, codes and helpers for the range change coalescer
// no dependencies; used by every module of the block
package rcc_pkg;

    // index width of starts and counts
    localparam int IDX_W = 24;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // input operation codes
    localparam logic [2:0] OP_MOD  = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_REM  = 3'd2;
    localparam logic [2:0] OP_QUI  = 3'd3;
    localparam logic [2:0] OP_READ = 3'd4;

    // result kinds
    typedef enum logic [1:0] {
        KIND_MOD = 2'd0,
        KIND_ADD = 2'd1,
        KIND_REM = 2'd2,
        KIND_QUI = 2'd3
    } kind_t;

    // item classes produced by the front
    typedef enum logic [1:0] {
        CLS_CHANGE  = 2'd0,
        CLS_QUIESCE = 2'd1,
        CLS_READ    = 2'd2
    } cls_t;

    // classified item carried through the queue
    typedef struct packed {
        cls_t             cls;
        kind_t            kind;
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] count;
    } item_t;

    // one result item
    typedef struct packed {
        kind_t            kind;
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] count;
        logic             last;
    } result_t;

    // saturate a grown count to the index range
    function automatic logic [IDX_W-1:0] sat_count(input logic [IDX_W:0] x);
        logic [IDX_W-1:0] r;
        if (x[IDX_W]) begin
            r = {IDX_W{1'b1}};
        end else begin
            r = x[IDX_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/range_change_coalescer_core.sv @@
// range_change_coalescer_core: items pass the front stage register, the queue and the result buffer in order
// throughput one input per cycle while results are taken; a quiesce with a change pending yields two
// results, written together into the two-entry result buffer in the back
// sustained rate is set by the single record update per cycle in the back part
// aresetn synchronous active low: clears pending and sent records, queue and buffers
// depends on rcc_pkg, rcc_front, rcc_queue, rcc_back
module range_change_coalescer_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [2:0]                s_op,
    input  logic [rcc_pkg::IDX_W-1:0] s_range_start,
    input  logic [rcc_pkg::IDX_W-1:0] s_range_count,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic [rcc_pkg::IDX_W-1:0] m_out_start,
    output logic [rcc_pkg::IDX_W-1:0] m_out_count,
    output logic                      m_last
);

    logic           f_valid, f_ready;
    rcc_pkg::item_t f_item;
    logic           q_valid, q_ready;
    rcc_pkg::item_t q_item;

    // decode and classify
    rcc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_range_start (s_range_start),
        .s_range_count (s_range_count),
        .item_valid    (f_valid),
        .item_ready    (f_ready),
        .item          (f_item)
    );

    // decoupling queue
    rcc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // coalescing and result output
    rcc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (q_valid),
        .item_ready  (q_ready),
        .item        (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_out_start (m_out_start),
        .m_out_count (m_out_count),
        .m_last      (m_last)
    );

endmodule

@@ rtl/rcc_front.sv @@
// rcc_front: input register stage that decodes and classifies events
// depends on rcc_pkg; feeds rcc_queue
module rcc_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_op,
    input  logic [rcc_pkg::IDX_W-1:0] s_range_start,
    input  logic [rcc_pkg::IDX_W-1:0] s_range_count,
    output logic                     item_valid,
    input  logic                     item_ready,
    output rcc_pkg::item_t           item
);

    logic           valid_reg;
    logic           valid_next;
    rcc_pkg::item_t item_reg;
    rcc_pkg::item_t item_next;
    logic           useful;
    logic           cnt_zero;

    assign s_ready    = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;
    assign cnt_zero   = (s_range_count == '0);

    // classify; zero-count changes and reads and unknown ops are dropped here
    always_comb begin
        useful          = 1'b0;
        item_next       = item_reg;
        item_next.start = s_range_start;
        item_next.count = s_range_count;
        item_next.kind  = rcc_pkg::kind_t'(s_op[1:0]);
        item_next.cls   = rcc_pkg::CLS_CHANGE;
        unique case (s_op)
            rcc_pkg::OP_MOD, rcc_pkg::OP_ADD, rcc_pkg::OP_REM: begin
                useful = !cnt_zero;
            end
            rcc_pkg::OP_QUI: begin
                useful        = 1'b1;
                item_next.cls = rcc_pkg::CLS_QUIESCE;
            end
            rcc_pkg::OP_READ: begin
                useful        = !cnt_zero;
                item_next.cls = rcc_pkg::CLS_READ;
            end
            default: begin
                useful = 1'b0;
            end
        endcase
    end

    // stage register
    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid && useful;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid && useful) begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/rcc_queue.sv @@
// rcc_queue: short register queue of classified items between front and back
// depends on rcc_pkg
module rcc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rcc_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output rcc_pkg::item_t out_item
);

    rcc_pkg::item_t                    entry_reg [rcc_pkg::QUEUE_DEPTH];
    logic [rcc_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [rcc_pkg::QPTR_W-1:0]        wr_ptr_next;
    logic [rcc_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [rcc_pkg::QPTR_W-1:0]        rd_ptr_next;
    logic [rcc_pkg::QCNT_W-1:0]        cnt_reg;
    logic [rcc_pkg::QCNT_W-1:0]        cnt_next;
    logic                              push;
    logic                              pop;

    assign in_ready  = (cnt_reg != rcc_pkg::QCNT_W'(rcc_pkg::QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            if (wr_ptr_reg == rcc_pkg::QPTR_W'(rcc_pkg::QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (pop) begin
            if (rd_ptr_reg == rcc_pkg::QPTR_W'(rcc_pkg::QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/rcc_back.sv @@
// rcc_back: pending/sent change records, merge rules and the result buffer
// depends on rcc_pkg; takes items from rcc_queue
module rcc_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  rcc_pkg::item_t            item,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic [rcc_pkg::IDX_W-1:0] m_out_start,
    output logic [rcc_pkg::IDX_W-1:0] m_out_count,
    output logic                      m_last
);

    localparam int W = rcc_pkg::IDX_W;

    // change records
    rcc_pkg::kind_t pend_kind_reg,  pend_kind_next;
    logic [W-1:0]   pend_start_reg, pend_start_next;
    logic [W-1:0]   pend_count_reg, pend_count_next;
    rcc_pkg::kind_t sent_kind_reg,  sent_kind_next;
    logic [W-1:0]   sent_start_reg, sent_start_next;
    logic [W-1:0]   sent_count_reg, sent_count_next;

    // two-entry result buffer
    rcc_pkg::result_t res_reg [2];
    logic             head_reg, head_next;
    logic [1:0]       cnt_reg,  cnt_next;
    logic [0:0]       tail0;
    logic [0:0]       tail1;

    // per-item results
    rcc_pkg::result_t r0, r1;
    logic [1:0]       n_res;
    logic [1:0]       free;
    logic             out_pop;
    logic             take;

    // arithmetic on the held records
    logic [W:0] p_end, n_end, sent_end, cnt_sum, m_end, m_span;
    logic [W-1:0] m_start;
    logic       mod_ok, add_ok, rem_ok, ra_ok, merge_ok, redundant, pend_any;
    logic       overlap;
    rcc_pkg::kind_t sk_eff;
    logic [W-1:0]   ss_eff, sc_eff;
    logic [W:0]     se_eff;

    assign out_pop     = m_valid && m_ready;
    assign m_valid     = (cnt_reg != 2'd0);
    assign m_kind      = res_reg[head_reg].kind;
    assign m_out_start = res_reg[head_reg].start;
    assign m_out_count = res_reg[head_reg].count;
    assign m_last      = res_reg[head_reg].last;
    assign free        = 2'd2 - cnt_reg + {1'b0, out_pop};
    assign take        = item_valid && (n_res <= free);
    assign item_ready  = (n_res <= free);
    assign tail0       = head_reg ^ cnt_reg[0];
    assign tail1       = ~tail0;

    // merge conditions against the pending record, redundancy check against the sent record
    always_comb begin
        pend_any = (pend_count_reg != '0);
        p_end    = {1'b0, pend_start_reg} + {1'b0, pend_count_reg};
        n_end    = {1'b0, item.start} + {1'b0, item.count};
        sent_end = {1'b0, sent_start_reg} + {1'b0, sent_count_reg};
        cnt_sum  = {1'b0, pend_count_reg} + {1'b0, item.count};
        m_start  = (item.start < pend_start_reg) ? item.start : pend_start_reg;
        m_end    = (n_end > p_end) ? n_end : p_end;
        m_span   = m_end - {1'b0, m_start};
        mod_ok   = (m_span <= cnt_sum);
        if (item.start >= pend_start_reg) begin
            add_ok = ({1'b0, item.start} <= p_end);
            rem_ok = (item.start == pend_start_reg);
        end else begin
            add_ok = (n_end >= {1'b0, pend_start_reg});
            rem_ok = add_ok;
        end
        ra_ok = (pend_kind_reg == rcc_pkg::KIND_REM) && (item.kind == rcc_pkg::KIND_ADD)
                && (item.start == pend_start_reg) && (item.count == pend_count_reg);
        merge_ok = 1'b0;
        if (pend_kind_reg == item.kind) begin
            unique case (item.kind)
                rcc_pkg::KIND_MOD: merge_ok = mod_ok;
                rcc_pkg::KIND_ADD: merge_ok = add_ok;
                default:           merge_ok = rem_ok;
            endcase
        end
        merge_ok  = merge_ok || ra_ok;
        redundant = (sent_kind_reg == rcc_pkg::KIND_MOD) && (item.kind == rcc_pkg::KIND_MOD)
                    && (item.start >= sent_start_reg) && (n_end <= sent_end);
    end

    // record update and result selection
    always_comb begin
        pend_kind_next  = pend_kind_reg;
        pend_start_next = pend_start_reg;
        pend_count_next = pend_count_reg;
        sent_kind_next  = sent_kind_reg;
        sent_start_next = sent_start_reg;
        sent_count_next = sent_count_reg;
        r0.kind  = pend_kind_reg;
        r0.start = pend_start_reg;
        r0.count = pend_count_reg;
        r0.last  = 1'b1;
        r1.kind  = rcc_pkg::KIND_QUI;
        r1.start = '0;
        r1.count = '0;
        r1.last  = 1'b1;
        n_res    = 2'd0;
        sk_eff   = sent_kind_reg;
        ss_eff   = sent_start_reg;
        sc_eff   = sent_count_reg;
        overlap  = 1'b0;
        unique case (item.cls)
            rcc_pkg::CLS_CHANGE: begin
                if (!pend_any) begin
                    if (!redundant) begin
                        pend_kind_next  = item.kind;
                        pend_start_next = item.start;
                        pend_count_next = item.count;
                    end
                end else if (merge_ok) begin
                    if (ra_ok && !(pend_kind_reg == item.kind)) begin
                        pend_kind_next = rcc_pkg::KIND_MOD;
                    end else if (item.kind == rcc_pkg::KIND_MOD) begin
                        pend_start_next = m_start;
                        pend_count_next = rcc_pkg::sat_count(m_span);
                    end else begin
                        if (item.start < pend_start_reg) begin
                            pend_start_next = item.start;
                        end
                        pend_count_next = rcc_pkg::sat_count(cnt_sum);
                    end
                end else begin
                    // flush the pending change, the new one takes its place
                    n_res           = 2'd1;
                    sent_kind_next  = pend_kind_reg;
                    sent_start_next = pend_start_reg;
                    sent_count_next = pend_count_reg;
                    pend_kind_next  = item.kind;
                    pend_start_next = item.start;
                    pend_count_next = item.count;
                end
            end
            rcc_pkg::CLS_QUIESCE: begin
                if (pend_any) begin
                    n_res           = 2'd2;
                    r0.last         = 1'b0;
                    sent_kind_next  = pend_kind_reg;
                    sent_start_next = pend_start_reg;
                    sent_count_next = pend_count_reg;
                    pend_count_next = '0;
                end else begin
                    n_res = 2'd1;
                    r0    = r1;
                end
            end
            rcc_pkg::CLS_READ: begin
                if (pend_any) begin
                    n_res           = 2'd1;
                    sk_eff          = pend_kind_reg;
                    ss_eff          = pend_start_reg;
                    sc_eff          = pend_count_reg;
                    sent_kind_next  = pend_kind_reg;
                    sent_start_next = pend_start_reg;
                    pend_count_next = '0;
                end
                se_eff  = {1'b0, ss_eff} + {1'b0, sc_eff};
                overlap = ((ss_eff >= item.start) && ({1'b0, ss_eff} < n_end)) ||
                          ((item.start >= ss_eff) && ({1'b0, item.start} < se_eff));
                if ((sk_eff == rcc_pkg::KIND_MOD) && (sc_eff != '0) && overlap) begin
                    sent_count_next = '0;
                end else begin
                    sent_count_next = sc_eff;
                end
            end
            default: begin
                n_res = 2'd0;
            end
        endcase
        se_eff = {1'b0, ss_eff} + {1'b0, sc_eff};
    end

    // buffer pointers
    always_comb begin
        head_next = head_reg ^ out_pop;
        cnt_next  = cnt_reg - {1'b0, out_pop} + (take ? n_res : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_kind_reg  <= rcc_pkg::KIND_MOD;
            pend_start_reg <= '0;
            pend_count_reg <= '0;
            sent_kind_reg  <= rcc_pkg::KIND_QUI;
            sent_start_reg <= '0;
            sent_count_reg <= '0;
            head_reg       <= 1'b0;
            cnt_reg        <= 2'd0;
        end else begin
            if (take) begin
                pend_kind_reg  <= pend_kind_next;
                pend_start_reg <= pend_start_next;
                pend_count_reg <= pend_count_next;
                sent_kind_reg  <= sent_kind_next;
                sent_start_reg <= sent_start_next;
                sent_count_reg <= sent_count_next;
            end
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
        end
    end

    // result buffer writes at the tail
    always_ff @(posedge aclk) begin
        if (take && (n_res != 2'd0)) begin
            res_reg[tail0] <= r0;
        end
        if (take && (n_res == 2'd2)) begin
            res_reg[tail1] <= r1;
        end
    end

endmodule
